// ===== rtl/rigid_body_2d_integrator_top_assert.svh =====
// Assertion macros for the port-level checker of the integrator.
`ifndef RIGID_BODY_2D_INTEGRATOR_TOP_ASSERT_SVH
`define RIGID_BODY_2D_INTEGRATOR_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define RB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rbi_pkg.sv =====
// Package with constants, states and helpers of the 2D rigid body integrator.
`timescale 1ns / 1ps
package rbi_pkg;
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_MASS     = 2'd0;
    localparam logic [1:0] REG_FRICTION = 2'd1;
    localparam logic [1:0] REG_DRAG     = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV_X, ST_ACC_X, ST_DIV_Y, ST_ACC_Y,
        ST_MUL_AX, ST_MUL_AY, ST_VEL, ST_SQX, ST_SQY, ST_SQRT,
        ST_MAG, ST_FR_X, ST_FR_Y, ST_DIVF_X, ST_DIVF_Y, ST_SUB,
        ST_DRAG, ST_FACT, ST_SCX, ST_SCY, ST_DISX, ST_DISY, ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// ===== rtl/rigid_body_2d_integrator_top.sv =====
// Top level of the 2D rigid body integrator with one shared multiplier and one shared div/sqrt unit.
// A request runs four divisions and a square root on the shared unit (two divisions when
// the velocity comes out zero), and the result then waits for m_axis_tready. One request
// at a time: s_axis_tready is high only when idle.
// Reset (aresetn low, synchronous) clears the velocity and loads default registers.
`timescale 1ns / 1ps
module rigid_body_2d_integrator_top #(
    parameter int FRACTION_BITS = rbi_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // force_x, force_y, gravity_x, gravity_y, frame_time, load_velocity,
    // new_velocity_x, new_velocity_y (bit 0 up), zero padded
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // displacement_x, displacement_y, velocity_out_x, velocity_out_y
    output logic [127:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [rbi_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam logic signed [65:0] ONE = 66'sd1 <<< FRACTION_BITS;

    logic [30:0] mass_reg, fric_reg, drag_reg;
    logic signed [31:0] vx_reg, vy_reg, vx_next, vy_next;
    logic signed [31:0] fx_reg, fy_reg, gx_reg, gy_reg, ax_reg, ay_reg;
    logic signed [31:0] fx_next, fy_next, gx_next, gy_next, ax_next, ay_next;
    logic [16:0] dt_reg, dt_next;
    logic signed [31:0] mag_reg, mag_next, fac_reg, fac_next;
    logic signed [31:0] frx_reg, frx_next, fry_reg, fry_next;
    logic signed [31:0] dx_reg, dx_next;
    logic [63:0] sq_reg, sq_next;
    logic [31:0] norm_reg, norm_next;
    logic [127:0] out_reg, out_next;
    rbi_pkg::state_t state_reg, state_next;

    // Shared iterative divider/root: restoring, one quotient bit per cycle.
    logic [95:0] num_reg, num_next;     // magnitude of dividend, shifted left
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;

    // Shared multiplier.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [65:0] q_signed;
    assign q_signed = neg_reg ? -$signed({2'b0, num_reg[63:0]}) : $signed({2'b0, num_reg[63:0]});

    wire cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            rbi_pkg::REG_MASS:     prdata = {1'b0, mass_reg};
            rbi_pkg::REG_FRICTION: prdata = {1'b0, fric_reg};
            rbi_pkg::REG_DRAG:     prdata = {1'b0, drag_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (state_reg == rbi_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == rbi_pkg::ST_OUT);
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg  <= 31'(ONE);
            fric_reg  <= (200 * ONE > 66'sh7fffffff) ? 31'h7fffffff : 31'(200 * ONE);
            drag_reg  <= 31'd0;
            vx_reg    <= '0;
            vy_reg    <= '0;
            state_reg <= rbi_pkg::ST_IDLE;
            busy_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    rbi_pkg::REG_MASS:     mass_reg <= pwdata[30:0];
                    rbi_pkg::REG_FRICTION: fric_reg <= pwdata[30:0];
                    rbi_pkg::REG_DRAG:     drag_reg <= pwdata[30:0];
                    default: ;
                endcase
            end
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
        fx_reg <= fx_next; fy_reg <= fy_next; gx_reg <= gx_next; gy_reg <= gy_next;
        ax_reg <= ax_next; ay_reg <= ay_next; dt_reg <= dt_next;
        mag_reg <= mag_next; fac_reg <= fac_next; frx_reg <= frx_next; fry_reg <= fry_next;
        dx_reg <= dx_next; sq_reg <= sq_next; norm_reg <= norm_next; out_reg <= out_next;
        num_reg <= num_next; rem_reg <= rem_next; den_reg <= den_next;
        cnt_reg <= cnt_next; neg_reg <= neg_next;
    end

    // Starts a signed division div_n / div_d with truncation toward zero.
    logic start_div, start_sqrt;
    logic signed [63:0] div_n;
    logic [63:0] div_d;

    always_comb begin
        logic [63:0] mag_n;
        logic signed [65:0] tmp;
        logic [95:0] nsh;
        state_next = state_reg;
        {vx_next, vy_next} = {vx_reg, vy_reg};
        {fx_next, fy_next, gx_next, gy_next} = {fx_reg, fy_reg, gx_reg, gy_reg};
        {ax_next, ay_next, dt_next} = {ax_reg, ay_reg, dt_reg};
        {mag_next, fac_next, frx_next, fry_next} = {mag_reg, fac_reg, frx_reg, fry_reg};
        {dx_next, sq_next, norm_next, out_next} = {dx_reg, sq_reg, norm_reg, out_reg};
        {num_next, rem_next, den_next, cnt_next, neg_next} =
            {num_reg, rem_reg, den_reg, cnt_reg, neg_reg};
        busy_next = busy_reg;
        mul_a = '0; mul_b = '0;
        start_div = 1'b0; start_sqrt = 1'b0; div_n = '0; div_d = '0;
        trial = '0; tmp = '0; mag_n = '0; nsh = '0;

        // Iteration step of the shared unit.
        if (busy_reg) begin
            if (cnt_reg[6]) begin
                // square root: two dividend bits a step
                trial = {1'b0, rem_reg[61:0], num_reg[95:94]} - {1'b0, den_reg[61:0], 2'b01};
                if (!trial[64]) begin
                    rem_next = trial[63:0];
                    den_next = {den_reg[62:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[61:0], num_reg[95:94]};
                    den_next = {den_reg[62:0], 1'b0};
                end
                num_next = {num_reg[93:0], 2'b00};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg[4:0] == 5'd0) busy_next = 1'b0;
            end else begin
                trial = {rem_reg, num_reg[95]} - {1'b0, den_reg};
                if (!trial[64]) rem_next = trial[63:0];
                else rem_next = {rem_reg[62:0], num_reg[95]};
                num_next = {num_reg[94:0], ~trial[64]};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            rbi_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    fx_next = s_axis_tdata[31:0];
                    fy_next = s_axis_tdata[63:32];
                    gx_next = s_axis_tdata[95:64];
                    gy_next = s_axis_tdata[127:96];
                    dt_next = s_axis_tdata[144:128];
                    if (s_axis_tdata[145]) begin
                        vx_next = s_axis_tdata[177:146];
                        vy_next = s_axis_tdata[209:178];
                    end
                    state_next = rbi_pkg::ST_DIV_X;
                end
            end
            rbi_pkg::ST_DIV_X: begin
                div_n = 64'(fx_reg) <<< FRACTION_BITS; div_d = 64'(mass_reg);
                start_div = 1'b1; state_next = rbi_pkg::ST_ACC_X;
            end
            rbi_pkg::ST_ACC_X: if (!busy_reg) begin
                tmp = (mass_reg == 0) ? ((fx_reg > 0) ? 66'sh7fffffff :
                      (fx_reg < 0) ? -66'sh80000000 : 66'sd0) : 66'(rbi_pkg::sat32(q_signed));
                ax_next = rbi_pkg::sat32(tmp + 66'(gx_reg));
                state_next = rbi_pkg::ST_DIV_Y;
            end
            rbi_pkg::ST_DIV_Y: begin
                div_n = 64'(fy_reg) <<< FRACTION_BITS; div_d = 64'(mass_reg);
                start_div = 1'b1; state_next = rbi_pkg::ST_ACC_Y;
            end
            rbi_pkg::ST_ACC_Y: if (!busy_reg) begin
                tmp = (mass_reg == 0) ? ((fy_reg > 0) ? 66'sh7fffffff :
                      (fy_reg < 0) ? -66'sh80000000 : 66'sd0) : 66'(rbi_pkg::sat32(q_signed));
                ay_next = rbi_pkg::sat32(tmp + 66'(gy_reg));
                state_next = rbi_pkg::ST_MUL_AX;
            end
            rbi_pkg::ST_MUL_AX: begin
                mul_a = 33'(ax_reg); mul_b = $signed({16'b0, dt_reg});
                ax_next = rbi_pkg::sat32(66'(rbi_pkg::sat32(mul_p / ONE)) + 66'(vx_reg));
                state_next = rbi_pkg::ST_MUL_AY;
            end
            rbi_pkg::ST_MUL_AY: begin
                mul_a = 33'(ay_reg); mul_b = $signed({16'b0, dt_reg});
                ay_next = rbi_pkg::sat32(66'(rbi_pkg::sat32(mul_p / ONE)) + 66'(vy_reg));
                state_next = rbi_pkg::ST_VEL;
            end
            rbi_pkg::ST_VEL: begin
                vx_next = ax_reg; vy_next = ay_reg;
                state_next = (ax_reg != 0 || ay_reg != 0) ? rbi_pkg::ST_SQX : rbi_pkg::ST_DISX;
            end
            rbi_pkg::ST_SQX: begin
                mul_a = 33'(vx_reg); mul_b = 33'(vx_reg);
                sq_next = 64'(mul_p); state_next = rbi_pkg::ST_SQY;
            end
            rbi_pkg::ST_SQY: begin
                mul_a = 33'(vy_reg); mul_b = 33'(vy_reg);
                sq_next = sq_reg + 64'(mul_p); state_next = rbi_pkg::ST_SQRT;
                start_sqrt = 1'b1;
            end
            rbi_pkg::ST_SQRT: if (!busy_reg) begin
                norm_next = (den_reg[31:0] == 0) ? 32'd1 : den_reg[31:0];
                state_next = rbi_pkg::ST_MAG;
            end
            rbi_pkg::ST_MAG: begin
                mul_a = 33'(fric_reg); mul_b = $signed({16'b0, dt_reg});
                mag_next = rbi_pkg::sat32(mul_p / ONE); state_next = rbi_pkg::ST_FR_X;
            end
            rbi_pkg::ST_FR_X: begin
                mul_a = 33'(vx_reg); mul_b = 33'(mag_reg);
                div_n = 64'(mul_p); div_d = 64'(norm_reg); start_div = 1'b1;
                state_next = rbi_pkg::ST_DIVF_X;
            end
            rbi_pkg::ST_DIVF_X: if (!busy_reg) begin
                frx_next = rbi_pkg::sat32(q_signed); state_next = rbi_pkg::ST_FR_Y;
            end
            rbi_pkg::ST_FR_Y: begin
                mul_a = 33'(vy_reg); mul_b = 33'(mag_reg);
                div_n = 64'(mul_p); div_d = 64'(norm_reg); start_div = 1'b1;
                state_next = rbi_pkg::ST_DIVF_Y;
            end
            rbi_pkg::ST_DIVF_Y: if (!busy_reg) begin
                fry_next = rbi_pkg::sat32(q_signed); state_next = rbi_pkg::ST_SUB;
            end
            rbi_pkg::ST_SUB: begin
                vx_next = rbi_pkg::sat32(66'(vx_reg) - 66'(frx_reg));
                vy_next = rbi_pkg::sat32(66'(vy_reg) - 66'(fry_reg));
                state_next = rbi_pkg::ST_DRAG;
            end
            rbi_pkg::ST_DRAG: begin
                mul_a = 33'(drag_reg); mul_b = $signed({16'b0, dt_reg});
                fac_next = rbi_pkg::sat32(mul_p / ONE); state_next = rbi_pkg::ST_FACT;
            end
            rbi_pkg::ST_FACT: begin
                fac_next = rbi_pkg::sat32(ONE - 66'(fac_reg)); state_next = rbi_pkg::ST_SCX;
            end
            rbi_pkg::ST_SCX: begin
                mul_a = 33'(vx_reg); mul_b = 33'(fac_reg);
                vx_next = rbi_pkg::sat32(mul_p / ONE); state_next = rbi_pkg::ST_SCY;
            end
            rbi_pkg::ST_SCY: begin
                mul_a = 33'(vy_reg); mul_b = 33'(fac_reg);
                vy_next = rbi_pkg::sat32(mul_p / ONE); state_next = rbi_pkg::ST_DISX;
            end
            rbi_pkg::ST_DISX: begin
                mul_a = 33'(vx_reg); mul_b = $signed({16'b0, dt_reg});
                dx_next = rbi_pkg::sat32(mul_p / ONE); state_next = rbi_pkg::ST_DISY;
            end
            rbi_pkg::ST_DISY: begin
                mul_a = 33'(vy_reg); mul_b = $signed({16'b0, dt_reg});
                out_next = {vy_reg, vx_reg, rbi_pkg::sat32(mul_p / ONE), dx_reg};
                state_next = rbi_pkg::ST_OUT;
            end
            rbi_pkg::ST_OUT: if (m_axis_tready) state_next = rbi_pkg::ST_IDLE;
            default: state_next = rbi_pkg::ST_IDLE;
        endcase

        // The divider counts 63 down to 0; the root counts 95 down to 64, so bit 6 tells
        // the two apart.
        if (start_div) begin
            neg_next = div_n[63] ^ 1'b0;
            mag_n = div_n[63] ? 64'(-div_n) : 64'(div_n);
            nsh = {mag_n, 32'd0};
            num_next = nsh;
            rem_next = '0; den_next = div_d; cnt_next = 7'd63; busy_next = 1'b1;
        end
        if (start_sqrt) begin
            num_next = {sq_next, 32'd0}; rem_next = '0; den_next = '0;
            cnt_next = 7'd95; busy_next = 1'b1;
        end
    end
endmodule

// ===== rtl/rbi_checker.sv =====
// Port-level checker for the integrator, bound to the top level.
`timescale 1ns / 1ps
`include "rigid_body_2d_integrator_top_assert.svh"
module rbi_checker (
    input logic aclk, aresetn, s_axis_tvalid, s_axis_tready,
    input logic m_axis_tvalid, m_axis_tready, pready
);
    `RB_ASSERT_IMP(a_busy_excl, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "ready while result pending")
    `RB_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
    `RB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `RB_ASSERT_IMP(a_pready, aclk, aresetn, 1'b1, pready, "pready low")
endmodule

bind rigid_body_2d_integrator_top rbi_checker u_rbi_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the 2D rigid body integrator top level.
`timescale 1ns / 1ps
module tb;
    localparam int ONE_Q = 1 << rbi_pkg::FRACTION_BITS_DEFAULT;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] disp_y;
        logic [31:0] disp_x;
    } motion_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // force_x, force_y, gravity_x, gravity_y, frame_time, load_velocity,
    // new_velocity_x, new_velocity_y (bit 0 up), zero padded
    logic [215:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // displacement_x, displacement_y, velocity_out_x, velocity_out_y
    logic [127:0] m_axis_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [rbi_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rigid_body_2d_integrator_top dut (.*);

    always #1 aclk = ~aclk;

    logic [215:0] frame_queue[$];
    motion_t motion_queue[$];
    int errors = 0;
    int cycles = 0;

    // Predictor state and register shadows.
    longint mass_q, friction_q, drag_q, vel_x_q, vel_y_q;

    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return sat((a * b) / ONE_Q);
    endfunction

    function automatic longint qdiv(input longint num, input longint den);
        if (den == 0) return (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
        return sat((num * ONE_Q) / den);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic motion_t integrate_frame(input logic [215:0] d);
        longint fx, fy, gx, gy, dt, ax, ay, vx, vy, norm, mag, fac;
        logic [63:0] sq;
        motion_t m;
        fx = longint'($signed(d[31:0]));
        fy = longint'($signed(d[63:32]));
        gx = longint'($signed(d[95:64]));
        gy = longint'($signed(d[127:96]));
        dt = longint'(d[144:128]);
        if (d[145]) begin
            vel_x_q = longint'($signed(d[177:146]));
            vel_y_q = longint'($signed(d[209:178]));
        end
        ax = sat(qdiv(fx, mass_q) + gx);
        ay = sat(qdiv(fy, mass_q) + gy);
        vx = sat(vel_x_q + qmul(ax, dt));
        vy = sat(vel_y_q + qmul(ay, dt));
        if (vx != 0 || vy != 0) begin
            sq = 64'(vx * vx) + 64'(vy * vy);
            norm = longint'(root_floor(sq));
            mag = qmul(friction_q, dt);
            if (norm < 1) norm = 1;
            vx = sat(vx - sat((vx * mag) / norm));
            vy = sat(vy - sat((vy * mag) / norm));
            fac = sat(ONE_Q - qmul(drag_q, dt));
            vx = qmul(vx, fac);
            vy = qmul(vy, fac);
        end
        vel_x_q = vx;
        vel_y_q = vy;
        m.disp_x = 32'(qmul(vx, dt));
        m.disp_y = 32'(qmul(vy, dt));
        m.vel_x = 32'(vx);
        m.vel_y = 32'(vy);
        return m;
    endfunction

    // Operands lean towards the extremes and small magnitudes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            5, 6: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [215:0] make_frame(input logic [31:0] fx, fy, gx, gy,
                                                input logic [16:0] dt, input logic ld,
                                                input logic [31:0] nvx, nvy);
        return {6'b0, nvy, nvx, ld, dt, gy, gx, fy, fx};
    endfunction

    function automatic logic [215:0] random_frame();
        logic [16:0] dt;
        case ($urandom_range(0, 7))
            0: dt = 17'($urandom_range(65537, 131071));
            1: dt = 17'd65536;
            2: dt = 17'd0;
            default: dt = 17'($urandom_range(0, 8192));
        endcase
        return make_frame(pick_word(), pick_word(), pick_word(), pick_word(), dt,
                          ($urandom_range(0, 3) == 0), pick_word(), pick_word());
    endfunction

    // Input-side handshake record and register shadow updates.
    logic in_fire = 1'b0;
    always @(posedge aclk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
        cycles <= cycles + 1;
        if (!aresetn) begin
            mass_q = ONE_Q;
            friction_q = 200 * ONE_Q;
            drag_q = 0;
            vel_x_q = 0;
            vel_y_q = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    rbi_pkg::REG_MASS: mass_q = longint'(pwdata[30:0]);
                    rbi_pkg::REG_FRICTION: friction_q = longint'(pwdata[30:0]);
                    rbi_pkg::REG_DRAG: drag_q = longint'(pwdata[30:0]);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                motion_queue.push_back(integrate_frame(s_axis_tdata));
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        motion_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (motion_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = motion_queue.pop_front();
                if (got.disp_x !== want.disp_x) begin
                    $display("%0t: disp_x exp %h got %h", $time, want.disp_x, got.disp_x);
                    errors++;
                end
                if (got.disp_y !== want.disp_y) begin
                    $display("%0t: disp_y exp %h got %h", $time, want.disp_y, got.disp_y);
                    errors++;
                end
                if (got.vel_x !== want.vel_x) begin
                    $display("%0t: vel_x exp %h got %h", $time, want.vel_x, got.vel_x);
                    errors++;
                end
                if (got.vel_y !== want.vel_y) begin
                    $display("%0t: vel_y exp %h got %h", $time, want.vel_y, got.vel_y);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("[rigid_body_2d_integrator_top] ERROR");
            $finish;
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn && !(s_axis_tvalid && !in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (frame_queue.size() > 0) begin
                s_axis_tdata <= frame_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stalls follow a mode that is picked again at random whenever its run ends.
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 400);
        end
        mode_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (cycles % 97) > 60;
        endcase
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until every frame has been taken and answered, then let the block settle.
    task automatic drain();
        while (frame_queue.size() > 0 || s_axis_tvalid || motion_queue.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [31:0] mass, fric, drag, input int count);
        drain();
        write_reg(rbi_pkg::REG_MASS, mass);
        write_reg(rbi_pkg::REG_FRICTION, fric);
        write_reg(rbi_pkg::REG_DRAG, drag);
        repeat (count) frame_queue.push_back(random_frame());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed frames under the reset register values: zero velocity, loads,
        // extreme forces and gravity, zero and over-one frame times.
        frame_queue.push_back(make_frame(0, 0, 0, 0, 17'd1000, 1'b0, 0, 0));
        frame_queue.push_back(make_frame(32'h10000, 0, 0, 32'hfff6_0000, 17'd1092,
                                         1'b0, 0, 0));
        frame_queue.push_back(make_frame(0, 0, 0, 0, 17'd65536, 1'b1,
                                         32'h0100_0000, 32'hff00_0000));
        frame_queue.push_back(make_frame(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                         32'h8000_0000, 17'd65536, 1'b0, 0, 0));
        frame_queue.push_back(make_frame(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                         32'h7fff_ffff, 17'h1ffff, 1'b0, 0, 0));
        frame_queue.push_back(make_frame(0, 0, 0, 0, 17'd0, 1'b1,
                                         32'h7fff_ffff, 32'h7fff_ffff));
        frame_queue.push_back(make_frame(0, 0, 0, 0, 17'h1ffff, 1'b1,
                                         32'h8000_0000, 32'h8000_0000));
        frame_queue.push_back(make_frame(0, 0, 0, 0, 17'd100, 1'b1, 32'd1, 0));
        frame_queue.push_back(make_frame(0, 0, 0, 0, 17'd100, 1'b1, 0, 32'hffff_ffff));
        frame_queue.push_back(make_frame(32'hffff_ffff, 32'd1, 0, 0, 17'd1, 1'b1, 0, 0));
        repeat (200) frame_queue.push_back(random_frame());
        // Register settings, extremes among them; each boundary waits for all results.
        run_phase(32'd1, 32'd0, 32'd0, 250);
        run_phase(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 250);
        run_phase(32'd65536, 32'd0, 32'd6554, 250);
        run_phase(32'd32768, 32'd655360, 32'd65536, 250);
        run_phase(32'd1 << 22, 32'd13107200, 32'd1 << 20, 250);
        run_phase($urandom_range(1, 1 << 24), $urandom_range(0, 1 << 20),
                  $urandom_range(0, 1 << 17), 300);
        run_phase(32'd65536, 32'd13107200, 32'd0, 250);
        drain();
        if (errors == 0) begin
            $display("[rigid_body_2d_integrator_top] OK");
        end else begin
            $display("[rigid_body_2d_integrator_top] ERROR");
        end
        $finish;
    end
endmodule
